// ----- rtl/core/xfa_pkg.sv -----
// xfa_pkg: shared constants, types and helpers of the x86 flag alu
// depends on nothing; imported by every module of the core
package xfa_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned ReqWidth  = 208;
   localparam int unsigned RspWidth  = 136;

   localparam logic [4:0] OP_ADD        = 5'd0;
   localparam logic [4:0] OP_SUB        = 5'd1;
   localparam logic [4:0] OP_XOR        = 5'd2;
   localparam logic [4:0] OP_AND        = 5'd3;
   localparam logic [4:0] OP_OR         = 5'd4;
   localparam logic [4:0] OP_CMP        = 5'd5;
   localparam logic [4:0] OP_TEST       = 5'd6;
   localparam logic [4:0] OP_NEG        = 5'd7;
   localparam logic [4:0] OP_NOT        = 5'd8;
   localparam logic [4:0] OP_INC        = 5'd9;
   localparam logic [4:0] OP_DEC        = 5'd10;
   localparam logic [4:0] OP_SHL        = 5'd11;
   localparam logic [4:0] OP_SHR        = 5'd12;
   localparam logic [4:0] OP_SAR        = 5'd13;
   localparam logic [4:0] OP_ROL        = 5'd14;
   localparam logic [4:0] OP_ROR        = 5'd15;
   localparam logic [4:0] OP_MUL        = 5'd16;
   localparam logic [4:0] OP_IMUL_WIDE  = 5'd17;
   localparam logic [4:0] OP_IMUL_TRUNC = 5'd18;
   localparam logic [4:0] OP_DIV        = 5'd19;
   localparam logic [4:0] OP_IDIV       = 5'd20;
   localparam logic [4:0] OP_MOVZX      = 5'd21;
   localparam logic [4:0] OP_MOVSX      = 5'd22;
   localparam logic [4:0] OP_COND       = 5'd23;

   localparam int unsigned FLAG_CF = 0;
   localparam int unsigned FLAG_PF = 1;
   localparam int unsigned FLAG_ZF = 2;
   localparam int unsigned FLAG_SF = 3;
   localparam int unsigned FLAG_OF = 4;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   localparam logic [6:0] MUL_STEPS_M1 = 7'd63;
   localparam logic [6:0] DIV_STEPS_M1 = 7'd127;

   typedef struct packed {
      logic start;
      logic is_div;
   } xfa_md_req_type;

   function automatic logic [4:0] szp_flags(input logic [DataWidth-1:0] r);
      logic [4:0] f;
      f = 5'd0;
      f[FLAG_PF] = ~^r[7:0];
      f[FLAG_ZF] = (r == '0);
      f[FLAG_SF] = r[DataWidth-1];
      return f;
   endfunction

endpackage

// ----- rtl/core/x86_flag_alu_core.sv -----
// x86_flag_alu_core: 64-bit alu with a five-bit x86 flag register
// states: S_EXEC then S_DONE; shifts add S_SHIFT and S_SFLAG; mul/div S_PREP to S_MFLAG
// flow control: one request at a time; next request taken once the result is registered
// the bit-serial multiply/divide unit and the one-bit-per-cycle shifter set the run time
// reset: synchronous, clears flags, sequencer and output valid
// uses xfa_pkg and xfa_muldiv
module x86_flag_alu_core
   import xfa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // operation, operand_a, operand_b, dividend_high, condition_code,
   // source_size, dest_is_32, zero pad
   input  logic [ReqWidth-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // result_low, result_high, flags_out, condition_true, zero pad
   output logic [RspWidth-1:0] rsp_tdata
);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_EXEC  = 10'b0000000010,
      S_SHIFT = 10'b0000000100,
      S_SFLAG = 10'b0000001000,
      S_PREP  = 10'b0000010000,
      S_MD    = 10'b0000100000,
      S_POST1 = 10'b0001000000,
      S_POST2 = 10'b0010000000,
      S_MFLAG = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } xfa_state_type;

   xfa_state_type        state_ff, state_in;
   logic [4:0]           op_ff, op_in;
   logic [DataWidth-1:0] a_ff, a_in, b_ff, b_in, dh_ff, dh_in;
   logic [3:0]           cc_ff, cc_in;
   logic [1:0]           ssz_ff, ssz_in;
   logic                 d32_ff, d32_in;
   logic                 nd_ff, nd_in, nv_ff, nv_in;
   logic [DataWidth-1:0] work_ff, work_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 cnt1_ff, cnt1_in;
   logic                 c_ff, c_in;
   logic [DataWidth-1:0] res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic [4:0]           fnew_ff, fnew_in;
   logic                 cond_ff, cond_in;
   logic [4:0]           flag_ff, flag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RspWidth-1:0]  rsp_data_ff, rsp_data_in;

   logic [DataWidth-1:0] x, y, sr;
   logic                 ci;
   logic [DataWidth:0]   sum;
   logic                 add_of;
   logic [DataWidth-1:0] sx;
   logic                 cv;
   logic                 out_free;
   logic                 md_done;
   logic [DataWidth-1:0] md_lo, md_hi;
   xfa_md_req_type       md_req;

   function automatic logic eval_cond(input logic [3:0] cc, input logic [4:0] f);
      logic v;
      case (cc[3:1])
         3'd0:    v = f[FLAG_OF];
         3'd1:    v = f[FLAG_CF];
         3'd2:    v = f[FLAG_ZF];
         3'd3:    v = f[FLAG_CF] | f[FLAG_ZF];
         3'd4:    v = f[FLAG_SF];
         3'd5:    v = f[FLAG_PF];
         3'd6:    v = f[FLAG_SF] ^ f[FLAG_OF];
         default: v = f[FLAG_ZF] | (f[FLAG_SF] ^ f[FLAG_OF]);
      endcase
      return cc[0] ? ~v : v;
   endfunction

   xfa_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .opa    (a_ff),
      .opb    (b_ff),
      .opdh   (dh_ff),
      .done   (md_done),
      .res_lo (md_lo),
      .res_hi (md_hi)
   );

   assign md_req.start  = (state_ff == S_PREP);
   assign md_req.is_div = (op_ff == OP_DIV) || (op_ff == OP_IDIV);

   // shared adder for add, sub, cmp, neg, inc, dec
   always_comb begin
      x  = a_ff;
      y  = b_ff;
      ci = 1'b0;
      case (op_ff)
         OP_SUB, OP_CMP: begin
            y  = ~b_ff;
            ci = 1'b1;
         end
         OP_NEG: begin
            x  = '0;
            y  = ~a_ff;
            ci = 1'b1;
         end
         OP_INC: begin
            y  = '0;
            ci = 1'b1;
         end
         OP_DEC: begin
            y  = '1;
         end
         default: begin
            y  = b_ff;
         end
      endcase
      sum    = {1'b0, x} + {1'b0, y} + {{DataWidth{1'b0}}, ci};
      sr     = sum[DataWidth-1:0];
      add_of = (~(x[DataWidth-1] ^ y[DataWidth-1])) & (x[DataWidth-1] ^ sr[DataWidth-1]);
      case (ssz_ff)
         SIZE_BYTE: sx = {{(DataWidth-8){a_ff[7]}}, a_ff[7:0]};
         SIZE_HALF: sx = {{(DataWidth-16){a_ff[15]}}, a_ff[15:0]};
         default:   sx = {{(DataWidth-32){a_ff[31]}}, a_ff[31:0]};
      endcase
   end

   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      dh_in        = dh_ff;
      cc_in        = cc_ff;
      ssz_in       = ssz_ff;
      d32_in       = d32_ff;
      nd_in        = nd_ff;
      nv_in        = nv_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      cnt1_in      = cnt1_ff;
      c_in         = c_ff;
      res_lo_in    = res_lo_ff;
      res_hi_in    = res_hi_ff;
      fnew_in      = fnew_ff;
      cond_in      = cond_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cv           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tdata[4:0];
               a_in     = req_tdata[68:5];
               b_in     = req_tdata[132:69];
               dh_in    = req_tdata[196:133];
               cc_in    = req_tdata[200:197];
               ssz_in   = req_tdata[202:201];
               d32_in   = req_tdata[203];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_lo_in = '0;
            res_hi_in = '0;
            cond_in   = 1'b0;
            fnew_in   = flag_ff;
            state_in  = S_DONE;
            case (op_ff)
               OP_ADD: begin
                  res_lo_in = sr;
                  fnew_in   = szp_flags(sr);
                  fnew_in[FLAG_CF] = sum[DataWidth];
                  fnew_in[FLAG_OF] = add_of;
               end
               OP_SUB, OP_NEG: begin
                  res_lo_in = sr;
                  fnew_in   = szp_flags(sr);
                  fnew_in[FLAG_CF] = ~sum[DataWidth];
                  fnew_in[FLAG_OF] = add_of;
               end
               OP_CMP: begin
                  fnew_in   = szp_flags(sr);
                  fnew_in[FLAG_CF] = ~sum[DataWidth];
                  fnew_in[FLAG_OF] = add_of;
               end
               OP_INC, OP_DEC: begin
                  res_lo_in = sr;
                  fnew_in   = szp_flags(sr);
                  fnew_in[FLAG_CF] = flag_ff[FLAG_CF];
                  fnew_in[FLAG_OF] = add_of;
               end
               OP_XOR: begin
                  res_lo_in = a_ff ^ b_ff;
                  fnew_in   = szp_flags(a_ff ^ b_ff);
               end
               OP_AND: begin
                  res_lo_in = a_ff & b_ff;
                  fnew_in   = szp_flags(a_ff & b_ff);
               end
               OP_OR: begin
                  res_lo_in = a_ff | b_ff;
                  fnew_in   = szp_flags(a_ff | b_ff);
               end
               OP_TEST: begin
                  fnew_in   = szp_flags(a_ff & b_ff);
               end
               OP_NOT: begin
                  res_lo_in = ~a_ff;
               end
               OP_SHL, OP_SHR, OP_SAR, OP_ROL, OP_ROR: begin
                  res_lo_in = a_ff;
                  work_in   = a_ff;
                  cnt_in    = b_ff[5:0];
                  cnt1_in   = (b_ff[5:0] == 6'd1);
                  if (b_ff[5:0] != '0) begin
                     state_in = S_SHIFT;
                  end
               end
               OP_MUL, OP_IMUL_WIDE, OP_IMUL_TRUNC, OP_DIV: begin
                  state_in = S_PREP;
               end
               OP_IDIV: begin
                  nd_in = dh_ff[DataWidth-1];
                  nv_in = b_ff[DataWidth-1];
                  if (b_ff[DataWidth-1]) begin
                     b_in = -b_ff;
                  end
                  if (dh_ff[DataWidth-1]) begin
                     a_in  = -a_ff;
                     dh_in = ~dh_ff + {{(DataWidth-1){1'b0}}, (a_ff == '0)};
                  end
                  state_in = S_PREP;
               end
               OP_MOVZX: begin
                  res_lo_in = (ssz_ff == SIZE_BYTE) ?
                              {{(DataWidth-8){1'b0}}, a_ff[7:0]} :
                              {{(DataWidth-16){1'b0}}, a_ff[15:0]};
               end
               OP_MOVSX: begin
                  res_lo_in = d32_ff ? {{(DataWidth-32){1'b0}}, sx[31:0]} : sx;
               end
               OP_COND: begin
                  cond_in = eval_cond(cc_ff, flag_ff);
               end
               default: begin
                  res_lo_in = '0;
               end
            endcase
         end
         S_SHIFT: begin
            case (op_ff)
               OP_SHL: begin
                  work_in = {work_ff[DataWidth-2:0], 1'b0};
                  c_in    = work_ff[DataWidth-1];
               end
               OP_SHR: begin
                  work_in = {1'b0, work_ff[DataWidth-1:1]};
                  c_in    = work_ff[0];
               end
               OP_SAR: begin
                  work_in = {work_ff[DataWidth-1], work_ff[DataWidth-1:1]};
                  c_in    = work_ff[0];
               end
               OP_ROL: begin
                  work_in = {work_ff[DataWidth-2:0], work_ff[DataWidth-1]};
               end
               default: begin
                  work_in = {work_ff[0], work_ff[DataWidth-1:1]};
               end
            endcase
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = S_SFLAG;
            end
         end
         S_SFLAG: begin
            res_lo_in = work_ff;
            case (op_ff)
               OP_SHL: begin
                  fnew_in = szp_flags(work_ff);
                  fnew_in[FLAG_CF] = c_ff;
                  fnew_in[FLAG_OF] = cnt1_ff & (work_ff[DataWidth-1] ^ c_ff);
               end
               OP_SHR: begin
                  fnew_in = szp_flags(work_ff);
                  fnew_in[FLAG_CF] = c_ff;
                  fnew_in[FLAG_OF] = cnt1_ff & a_ff[DataWidth-1];
               end
               OP_SAR: begin
                  fnew_in = szp_flags(work_ff);
                  fnew_in[FLAG_CF] = c_ff;
               end
               OP_ROL: begin
                  fnew_in = flag_ff;
                  fnew_in[FLAG_CF] = work_ff[0];
                  fnew_in[FLAG_OF] = cnt1_ff & (work_ff[DataWidth-1] ^ work_ff[0]);
               end
               default: begin
                  fnew_in = flag_ff;
                  fnew_in[FLAG_CF] = work_ff[DataWidth-1];
                  fnew_in[FLAG_OF] = cnt1_ff &
                                     (work_ff[DataWidth-1] ^ work_ff[DataWidth-2]);
               end
            endcase
            state_in = S_DONE;
         end
         S_PREP: begin
            state_in = S_MD;
         end
         S_MD: begin
            if (md_done) begin
               res_lo_in = md_lo;
               res_hi_in = md_hi;
               state_in  = S_POST1;
            end
         end
         S_POST1: begin
            if (op_ff == OP_IDIV) begin
               if (nd_ff ^ nv_ff) begin
                  res_lo_in = -res_lo_ff;
               end
               if (nd_ff) begin
                  res_hi_in = -res_hi_ff;
               end
            end else if ((op_ff == OP_IMUL_WIDE || op_ff == OP_IMUL_TRUNC) &&
                         a_ff[DataWidth-1]) begin
               res_hi_in = res_hi_ff - b_ff;
            end
            state_in = S_POST2;
         end
         S_POST2: begin
            if ((op_ff == OP_IMUL_WIDE || op_ff == OP_IMUL_TRUNC) && b_ff[DataWidth-1]) begin
               res_hi_in = res_hi_ff - a_ff;
            end
            state_in = S_MFLAG;
         end
         S_MFLAG: begin
            fnew_in = flag_ff;
            if (op_ff == OP_MUL) begin
               cv = (res_hi_ff != '0);
               fnew_in[FLAG_CF] = cv;
               fnew_in[FLAG_OF] = cv;
            end else if (op_ff == OP_IMUL_WIDE || op_ff == OP_IMUL_TRUNC) begin
               cv = (res_hi_ff != {DataWidth{res_lo_ff[DataWidth-1]}});
               fnew_in[FLAG_CF] = cv;
               fnew_in[FLAG_OF] = cv;
            end
            if (op_ff == OP_IMUL_TRUNC) begin
               res_hi_in = '0;
            end
            cond_in  = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               flag_in      = fnew_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, cond_ff, fnew_ff, res_hi_ff, res_lo_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         flag_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      dh_ff       <= dh_in;
      cc_ff       <= cc_in;
      ssz_ff      <= ssz_in;
      d32_ff      <= d32_in;
      nd_ff       <= nd_in;
      nv_ff       <= nv_in;
      work_ff     <= work_in;
      cnt_ff      <= cnt_in;
      cnt1_ff     <= cnt1_in;
      c_ff        <= c_in;
      res_lo_ff   <= res_lo_in;
      res_hi_ff   <= res_hi_in;
      fnew_ff     <= fnew_in;
      cond_ff     <= cond_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/xfa_muldiv.sv -----
// xfa_muldiv: bit-serial shift-add multiplier and restoring divider
// one product or quotient bit per cycle; uses xfa_pkg
module xfa_muldiv
   import xfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  xfa_md_req_type       md_req,
   input  logic [DataWidth-1:0] opa,
   input  logic [DataWidth-1:0] opb,
   input  logic [DataWidth-1:0] opdh,
   output logic                 done,
   output logic [DataWidth-1:0] res_lo,
   output logic [DataWidth-1:0] res_hi
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic                     div_ff, div_in;
   logic [6:0]               cnt_ff, cnt_in;
   logic [DataWidth-1:0]     d_ff, d_in;
   logic [DataWidth-1:0]     rem_ff, rem_in;
   logic [2*DataWidth-1:0]   num_ff, num_in;
   logic [DataWidth:0]       msum;
   logic [DataWidth:0]       trial;
   logic [DataWidth:0]       diff;
   logic                     ge;

   always_comb begin
      msum  = {1'b0, rem_ff} + (num_ff[0] ? {1'b0, d_ff} : '0);
      trial = {rem_ff, num_ff[2*DataWidth-1]};
      diff  = {1'b0, trial[DataWidth-1:0]} - {1'b0, d_ff};
      ge    = trial[DataWidth] | ~diff[DataWidth];

      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      if (md_req.start) begin
         busy_in = 1'b1;
         div_in  = md_req.is_div;
         rem_in  = '0;
         if (md_req.is_div) begin
            cnt_in = DIV_STEPS_M1;
            d_in   = opb;
            num_in = {opdh, opa};
         end else begin
            cnt_in = MUL_STEPS_M1;
            d_in   = opa;
            num_in = {{DataWidth{1'b0}}, opb};
         end
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_in = ge ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
            num_in = {num_ff[2*DataWidth-2:0], ge};
         end else begin
            rem_in = msum[DataWidth:1];
            num_in = {num_ff[2*DataWidth-1:DataWidth], msum[0], num_ff[DataWidth-1:1]};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign done   = done_ff;
   assign res_lo = num_ff[DataWidth-1:0];
   assign res_hi = rem_ff;

endmodule

// ----- rtl/core/xfa_checker.sv -----
// xfa_checker: port-level assertions for x86_flag_alu_core, bound to the top level
// depends on xfa_pkg and x86_flag_alu_core
module xfa_checker
   import xfa_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspWidth-1:0] rsp_tdata
);

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // one request in flight: req_tready stays low in S_EXEC and in the state that follows it
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken while busy");

   // pad bits of the response stay clear
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspWidth-1:RspWidth-2] == 2'b00)
      else $error("response pad bits set");

endmodule

bind x86_flag_alu_core xfa_checker u_xfa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/testbench.sv -----
// testbench for x86_flag_alu_core: directed then random alu requests, own flag predictor
// depends on xfa_pkg and the core rtl
module testbench;
   import xfa_pkg::*;

   typedef struct packed {
      logic [4:0]  op;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] dh;
      logic [3:0]  cc;
      logic [1:0]  ssz;
      logic        d32;
   } alu_req_t;

   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  flags;
      logic        cond;
   } alu_rsp_t;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspWidth-1:0] rsp_tdata;

   alu_req_t pending_reqs[$];
   alu_rsp_t expected_rsps[$];
   logic [4:0] model_flags;
   int  error_count;
   int  stall_pct;
   bit  stimulus_done;
   bit  hold_off;
   int  quiet_cycles;
   bit  req_accepted;

   x86_flag_alu_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [4:0] szp(input logic [63:0] r);
      logic [4:0] f;
      f = '0;
      f[FLAG_PF] = ~^r[7:0];
      f[FLAG_ZF] = (r == 64'd0);
      f[FLAG_SF] = r[63];
      return f;
   endfunction

   function automatic logic [4:0] add_fl(input logic [63:0] a, b, r);
      logic [4:0] f;
      f = szp(r);
      f[FLAG_CF] = r < a;
      f[FLAG_OF] = (~(a[63] ^ b[63])) & (a[63] ^ r[63]);
      return f;
   endfunction

   function automatic logic [4:0] sub_fl(input logic [63:0] a, b, r);
      logic [4:0] f;
      f = szp(r);
      f[FLAG_CF] = a < b;
      f[FLAG_OF] = (a[63] ^ b[63]) & (a[63] ^ r[63]);
      return f;
   endfunction

   // restoring division with a carried remainder bit
   task automatic long_divide(input logic [63:0] hi, lo, d,
                              output logic [63:0] q, r);
      logic [127:0] dvd;
      logic         carry;
      dvd = {hi, lo};
      q = '0;
      r = '0;
      for (int i = 127; i >= 0; i--) begin
         carry = r[63];
         r = {r[62:0], dvd[i]};
         q = q << 1;
         if (carry || r >= d) begin
            r = r - d;
            q[0] = 1'b1;
         end
      end
   endtask

   function automatic logic cond_holds(input logic [3:0] cc, input logic [4:0] f);
      logic v;
      case (cc[3:1])
         3'd0: v = f[FLAG_OF];
         3'd1: v = f[FLAG_CF];
         3'd2: v = f[FLAG_ZF];
         3'd3: v = f[FLAG_CF] | f[FLAG_ZF];
         3'd4: v = f[FLAG_SF];
         3'd5: v = f[FLAG_PF];
         3'd6: v = f[FLAG_SF] ^ f[FLAG_OF];
         default: v = f[FLAG_ZF] | (f[FLAG_SF] ^ f[FLAG_OF]);
      endcase
      return cc[0] ? ~v : v;
   endfunction

   task automatic predict_alu(input alu_req_t q, output alu_rsp_t o);
      logic [4:0]   f;
      logic [63:0]  lo, hi, c, ud, uh, ul;
      logic [127:0] p;
      logic [5:0]   cnt;
      logic         nd, nv;
      f = model_flags;
      lo = '0;
      hi = '0;
      o.cond = 1'b0;
      cnt = q.b[5:0];
      case (q.op)
         OP_ADD: begin lo = q.a + q.b; f = add_fl(q.a, q.b, lo); end
         OP_SUB: begin lo = q.a - q.b; f = sub_fl(q.a, q.b, lo); end
         OP_XOR: begin lo = q.a ^ q.b; f = szp(lo); end
         OP_AND: begin lo = q.a & q.b; f = szp(lo); end
         OP_OR:  begin lo = q.a | q.b; f = szp(lo); end
         OP_CMP: f = sub_fl(q.a, q.b, q.a - q.b);
         OP_TEST: f = szp(q.a & q.b);
         OP_NEG: begin lo = 64'd0 - q.a; f = sub_fl(64'd0, q.a, lo); end
         OP_NOT: lo = ~q.a;
         OP_INC: begin
            lo = q.a + 64'd1;
            f = add_fl(q.a, 64'd1, lo);
            f[FLAG_CF] = model_flags[FLAG_CF];
         end
         OP_DEC: begin
            lo = q.a - 64'd1;
            f = sub_fl(q.a, 64'd1, lo);
            f[FLAG_CF] = model_flags[FLAG_CF];
         end
         OP_SHL, OP_SHR, OP_SAR, OP_ROL, OP_ROR: begin
            lo = q.a;
            if (cnt != 0) begin
               case (q.op)
                  OP_SHL: begin
                     lo = q.a << cnt;
                     f = szp(lo);
                     f[FLAG_CF] = q.a[64 - cnt];
                     f[FLAG_OF] = (cnt == 1) & (lo[63] ^ f[FLAG_CF]);
                  end
                  OP_SHR, OP_SAR: begin
                     lo = q.a >> cnt;
                     if (q.op == OP_SAR) lo = $signed(q.a) >>> cnt;
                     f = szp(lo);
                     f[FLAG_CF] = q.a[cnt - 1];
                     f[FLAG_OF] = (q.op == OP_SHR) & (cnt == 1) & q.a[63];
                  end
                  OP_ROL: begin
                     lo = (q.a << cnt) | (q.a >> (64 - cnt));
                     f[FLAG_CF] = lo[0];
                     f[FLAG_OF] = (cnt == 1) & (lo[63] ^ lo[0]);
                  end
                  default: begin
                     lo = (q.a >> cnt) | (q.a << (64 - cnt));
                     f[FLAG_CF] = lo[63];
                     f[FLAG_OF] = (cnt == 1) & (lo[63] ^ lo[62]);
                  end
               endcase
            end
         end
         OP_MUL: begin
            p = {64'd0, q.a} * {64'd0, q.b};
            {hi, lo} = p;
            f[FLAG_CF] = hi != 0;
            f[FLAG_OF] = hi != 0;
         end
         OP_IMUL_WIDE, OP_IMUL_TRUNC: begin
            p = {{64{q.a[63]}}, q.a} * {{64{q.b[63]}}, q.b};
            {hi, lo} = p;
            c = {64{lo[63]}};
            f[FLAG_CF] = hi != c;
            f[FLAG_OF] = hi != c;
            if (q.op == OP_IMUL_TRUNC) hi = '0;
         end
         OP_DIV: long_divide(q.dh, q.a, q.b, lo, hi);
         OP_IDIV: begin
            nd = q.dh[63];
            nv = q.b[63];
            ud = nv ? 64'd0 - q.b : q.b;
            {uh, ul} = nd ? 128'd0 - {q.dh, q.a} : {q.dh, q.a};
            long_divide(uh, ul, ud, lo, hi);
            if (nd != nv) lo = 64'd0 - lo;
            if (nd) hi = 64'd0 - hi;
         end
         OP_MOVZX: lo = (q.ssz == SIZE_BYTE) ? {56'd0, q.a[7:0]} : {48'd0, q.a[15:0]};
         OP_MOVSX: begin
            if (q.ssz == SIZE_BYTE) lo = {{56{q.a[7]}}, q.a[7:0]};
            else if (q.ssz == SIZE_HALF) lo = {{48{q.a[15]}}, q.a[15:0]};
            else lo = {{32{q.a[31]}}, q.a[31:0]};
            if (q.d32) lo[63:32] = '0;
         end
         OP_COND: o.cond = cond_holds(q.cc, f);
         default: ;
      endcase
      model_flags = f;
      o.lo = lo;
      o.hi = hi;
      o.flags = f;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got, want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] edge_val();
      case ($urandom_range(0, 7))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7fff_ffff_ffff_ffff;
         4: return 64'd1;
         5: return {32'd0, $urandom} >> $urandom_range(0, 31);
         default: return rand64();
      endcase
   endfunction

   task automatic add_req(input logic [4:0] op, input logic [63:0] a, b, dh);
      alu_req_t q;
      q.op = op;
      q.a = a;
      q.b = b;
      q.dh = dh;
      q.cc = 4'($urandom_range(0, 15));
      q.ssz = 2'($urandom_range(0, 3));
      q.d32 = 1'($urandom_range(0, 1));
      pending_reqs.push_back(q);
   endtask

   // driver
   always @(negedge clock) begin
      alu_req_t q;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_accepted) begin
         if (pending_reqs.size() != 0 && !hold_off &&
             $urandom_range(0, 99) >= stall_pct) begin
            q = pending_reqs.pop_front();
            req_tdata <= ReqWidth'(q.op) | (ReqWidth'(q.a) << 5) | (ReqWidth'(q.b) << 69)
                       | (ReqWidth'(q.dh) << 133) | (ReqWidth'(q.cc) << 197)
                       | (ReqWidth'(q.ssz) << 201) | (ReqWidth'(q.d32) << 203);
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      alu_req_t q;
      alu_rsp_t e;
      alu_rsp_t g;
      bit       moved;
      moved = 1'b0;
      req_accepted <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            q.op = req_tdata[4:0];
            q.a = req_tdata[68:5];
            q.b = req_tdata[132:69];
            q.dh = req_tdata[196:133];
            q.cc = req_tdata[200:197];
            q.ssz = req_tdata[202:201];
            q.d32 = req_tdata[203];
            predict_alu(q, e);
            expected_rsps.push_back(e);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            g.lo = rsp_tdata[63:0];
            g.hi = rsp_tdata[127:64];
            g.flags = rsp_tdata[132:128];
            g.cond = rsp_tdata[133];
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected response", g.lo, 64'd0);
            end else begin
               e = expected_rsps.pop_front();
               if (g.lo !== e.lo) report_mismatch("result_low", g.lo, e.lo);
               if (g.hi !== e.hi) report_mismatch("result_high", g.hi, e.hi);
               if (g.flags !== e.flags) report_mismatch("flags_out", g.flags, e.flags);
               if (g.cond !== e.cond) report_mismatch("condition_true", g.cond, e.cond);
            end
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles > 5000) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      logic [4:0] op;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      model_flags = '0;
      error_count = 0;
      stall_pct = 36;
      hold_off = 1'b0;
      quiet_cycles = 0;
      req_accepted = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: each operation, extremes, zero count, zero divisor, overflow
      for (int i = 0; i < 24; i++) add_req(5'(i), '1, 64'h8000_0000_0000_0001, '1);
      add_req(OP_SHL, 64'h8000_0000_0000_0001, 64'd64, '0);
      add_req(OP_DIV, 64'd5, 64'd0, 64'd3);
      add_req(OP_DIV, '0, 64'd1, 64'd7);
      add_req(OP_IDIV, '0, '1, 64'h8000_0000_0000_0000);
      add_req(OP_INC, 64'h7fff_ffff_ffff_ffff, '0, '0);
      add_req(5'd25, '1, '1, '1);

      // pause until everything issued so far has returned
      wait (pending_reqs.size() == 0);
      hold_off = 1'b1;
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_tvalid);
      hold_off = 1'b0;

      for (int i = 0; i < 600; i++) begin
         if (i == 200) begin
            wait (pending_reqs.size() == 0);
            stall_pct = 0;
         end
         if (i == 300) begin
            wait (pending_reqs.size() == 0);
            stall_pct = 36;
         end
         op = ($urandom_range(0, 39) == 0) ? 5'($urandom_range(24, 31))
                                            : 5'($urandom_range(0, 23));
         // divisions mostly kept in range, shifts mostly with small counts
         if (op == OP_DIV && $urandom_range(0, 3) != 0) begin
            add_req(op, rand64(), rand64() | 64'd1, {32'd0, $urandom} >> 8);
         end else if ((op == OP_IDIV) && $urandom_range(0, 3) != 0) begin
            add_req(op, rand64(), rand64() | 64'h100, {64{$urandom_range(0, 1) == 1}});
         end else if (op >= OP_SHL && op <= OP_ROR && $urandom_range(0, 1) == 1) begin
            add_req(op, edge_val(), 64'($urandom_range(0, 3)), rand64());
         end else begin
            add_req(op, edge_val(), edge_val(), edge_val());
         end
         if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 4);
      end

      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
